### hdl/sba_pkg.sv
package sba_pkg;

    // field widths
    localparam int OP_W    = 2;
    localparam int START_W = 10;
    localparam int LEN_W   = 11;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 11;
    localparam int SECT_W  = 11;   // sector index / count inside the medium
    localparam int SUM_W   = 12;   // start + length
    localparam int WORD_W  = 64;   // map bits per memory word
    localparam int BIT_W   = 6;    // bit index inside a word
    localparam int WIDX_W  = SECT_W - BIT_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // opcodes
    localparam logic [OP_W-1:0] OP_MARK_USED = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND      = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE_ERR = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [START_W-1:0] start_sector;
        logic [LEN_W-1:0]   range_length;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [START_W-1:0] extent_start;
        logic [LEN_W-1:0]   extent_length;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic clr;     // write one zero word of the clearing pass
        logic load;    // latch the request
        logic check;   // decode request, set up walk
        logic rd;      // read current map word
        logic mwr;     // write back marked word, advance
        logic seval;   // evaluate search on current word
        logic emit;    // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic go_mark;
        logic go_search;
        logic mark_last;
        logic sdone;
        logic sstay;
        logic out_free;
    } t_sts;

endpackage

### hdl/sba_req_if.sv
interface sba_req_if;
    logic                              valid;
    logic                              ready;
    logic [sba_pkg::OP_W-1:0]          opcode;
    logic [sba_pkg::START_W-1:0]       start_sector;
    logic [sba_pkg::LEN_W-1:0]         range_length;

    modport source (output valid, output opcode, output start_sector, output range_length,
                    input ready);
    modport sink (input valid, input opcode, input start_sector, input range_length,
                  output ready);
endinterface

### hdl/sba_rsp_if.sv
interface sba_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [sba_pkg::STAT_W-1:0]        status;
    logic [sba_pkg::START_W-1:0]       extent_start;
    logic [sba_pkg::LEN_W-1:0]         extent_length;

    modport source (output valid, output status, output extent_start, output extent_length,
                    input ready);
    modport sink (input valid, input status, input extent_start, input extent_length,
                  output ready);
endinterface

### hdl/sba_ram.sv
module sba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/sba_ctrl.sv
module sba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  sba_pkg::t_sts i_sts,
    output sba_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MRD,
        S_MWR,
        S_SRD,
        S_SEVAL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.go_mark) begin
                    n_state = S_MRD;
                end else if (i_sts.go_search) begin
                    n_state = S_SRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MWR;
            end
            S_MWR: begin
                o_cmd.mwr = 1'b1;
                n_state   = i_sts.mark_last ? S_DONE : S_MRD;
            end
            S_SRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SEVAL;
            end
            S_SEVAL: begin
                o_cmd.seval = 1'b1;
                if (i_sts.sdone) begin
                    n_state = S_DONE;
                end else if (i_sts.sstay) begin
                    n_state = S_SEVAL;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_req_ready = r_ready;

endmodule

### hdl/sba_dp.sv
module sba_dp #(
    parameter int MAX_SECTORS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sba_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  sba_pkg::t_req               i_req,
    input  sba_pkg::t_cmd               i_cmd,
    output sba_pkg::t_sts               o_sts,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output sba_pkg::t_rsp               o_rsp
);

    localparam int MAP_WORDS = (MAX_SECTORS + sba_pkg::WORD_W - 1) / sba_pkg::WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    // largest count the 11-bit register can select
    localparam int CAP       = (MAX_SECTORS < 2047) ? MAX_SECTORS : 2047;

    localparam logic [sba_pkg::WORD_W-1:0] ALL1 = '1;

    // index of lowest set bit
    function automatic logic [sba_pkg::BIT_W-1:0] lowest_set(
        input logic [sba_pkg::WORD_W-1:0] v
    );
        logic [sba_pkg::BIT_W-1:0] idx;
        idx = '0;
        for (int i = sba_pkg::WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = sba_pkg::BIT_W'(i);
            end
        end
        return idx;
    endfunction

    logic [sba_pkg::CFG_W-1:0]    r_cfg;
    logic [AW-1:0]                r_clr_addr;
    logic [sba_pkg::OP_W-1:0]     r_op;
    logic [sba_pkg::START_W-1:0]  r_start;
    logic [sba_pkg::LEN_W-1:0]    r_len;
    logic [sba_pkg::SECT_W-1:0]   r_n;
    logic [sba_pkg::SUM_W-1:0]    r_end;
    logic [sba_pkg::WIDX_W-1:0]   r_word;
    logic [sba_pkg::BIT_W-1:0]    r_lo;
    logic                         r_phase2;
    logic [sba_pkg::STAT_W-1:0]   r_status;
    logic [sba_pkg::START_W-1:0]  r_ext_start;
    logic [sba_pkg::LEN_W-1:0]    r_ext_len;
    logic                         r_out_valid;
    sba_pkg::t_rsp                r_out;

    logic [sba_pkg::SECT_W-1:0]   eff_n;
    logic [sba_pkg::SUM_W-1:0]    sum;
    logic                         is_mark;
    logic                         range_bad;
    logic                         search_empty;
    logic [sba_pkg::SUM_W-1:0]    end_m1;
    logic [sba_pkg::SECT_W-1:0]   n_m1;
    logic                         mark_last;
    logic                         search_last;
    logic [sba_pkg::WORD_W-1:0]   rdata;
    logic [sba_pkg::WORD_W-1:0]   mark_mask;
    logic [sba_pkg::WORD_W-1:0]   mark_word;
    logic [sba_pkg::WORD_W-1:0]   stop;
    logic [sba_pkg::WORD_W-1:0]   masked;
    logic                         found;
    logic [sba_pkg::BIT_W-1:0]    idx;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [sba_pkg::WORD_W-1:0]   ram_wdata;

    assign eff_n = (int'(r_cfg) > CAP) ? sba_pkg::SECT_W'(CAP) : r_cfg;

    assign sum          = sba_pkg::SUM_W'(r_start) + sba_pkg::SUM_W'(r_len);
    assign is_mark      = (r_op == sba_pkg::OP_MARK_USED) || (r_op == sba_pkg::OP_MARK_FREE);
    assign range_bad    = sum > sba_pkg::SUM_W'(r_n);
    assign search_empty = sba_pkg::SECT_W'(r_start) >= r_n;

    assign end_m1      = r_end - sba_pkg::SUM_W'(1);
    assign n_m1        = r_n - sba_pkg::SECT_W'(1);
    assign mark_last   = r_word == end_m1[sba_pkg::SECT_W-1:sba_pkg::BIT_W];
    assign search_last = r_word == n_m1[sba_pkg::SECT_W-1:sba_pkg::BIT_W];

    // bits of the current word inside the mark range
    always_comb begin
        mark_mask = ALL1 << r_lo;
        if (mark_last) begin
            mark_mask = mark_mask
                      & (ALL1 >> (sba_pkg::BIT_W'(sba_pkg::WORD_W - 1)
                                   - end_m1[sba_pkg::BIT_W-1:0]));
        end
        mark_word = (r_op == sba_pkg::OP_MARK_USED) ? (rdata | mark_mask)
                                                   : (rdata & ~mark_mask);
    end

    // sectors past the medium end count as used
    always_comb begin
        stop = rdata;
        if (r_word == r_n[sba_pkg::SECT_W-1:sba_pkg::BIT_W]) begin
            stop = stop | (ALL1 << r_n[sba_pkg::BIT_W-1:0]);
        end
        masked = (r_phase2 ? stop : ~stop) & (ALL1 << r_lo);
        found  = |masked;
        idx    = lowest_set(masked);
    end

    always_comb begin
        ram_we    = i_cmd.clr || i_cmd.mwr;
        ram_waddr = i_cmd.clr ? r_clr_addr : AW'(r_word);
        ram_wdata = i_cmd.clr ? '0 : mark_word;
    end

    sba_ram #(
        .WIDTH(sba_pkg::WORD_W),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd),
        .i_raddr(AW'(r_word)),
        .o_rdata(rdata)
    );

    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = r_clr_addr == AW'(MAP_WORDS - 1);
        o_sts.go_mark   = is_mark && !range_bad && (r_len != '0);
        o_sts.go_search = (r_op == sba_pkg::OP_FIND) && !search_empty;
        o_sts.mark_last = mark_last;
        o_sts.sstay     = !r_phase2 && found;
        o_sts.sdone     = (r_phase2 && found) || (!found && search_last);
        o_sts.out_free  = !r_out_valid || i_rsp_ready;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= sba_pkg::CFG_RESET;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_req.opcode;
            r_start <= i_req.start_sector;
            r_len   <= i_req.range_length;
            r_n     <= eff_n;
        end
        if (i_cmd.check) begin
            r_end       <= sum;
            r_word      <= sba_pkg::WIDX_W'(r_start[sba_pkg::START_W-1:sba_pkg::BIT_W]);
            r_lo        <= r_start[sba_pkg::BIT_W-1:0];
            r_phase2    <= 1'b0;
            r_ext_start <= '0;
            r_ext_len   <= '0;
            if (is_mark && range_bad) begin
                r_status <= sba_pkg::ST_RANGE_ERR;
            end else if ((r_op == sba_pkg::OP_FIND) && search_empty) begin
                r_status <= sba_pkg::ST_NO_SPACE;
            end else begin
                r_status <= sba_pkg::ST_OK;
            end
        end
        if (i_cmd.mwr) begin
            r_word <= r_word + sba_pkg::WIDX_W'(1);
            r_lo   <= '0;
        end
        if (i_cmd.seval) begin
            if (!r_phase2) begin
                if (found) begin
                    r_ext_start <= sba_pkg::START_W'({r_word, idx});
                    r_phase2    <= 1'b1;
                    r_lo        <= idx;
                end else if (search_last) begin
                    r_status <= sba_pkg::ST_NO_SPACE;
                end else begin
                    r_word <= r_word + sba_pkg::WIDX_W'(1);
                    r_lo   <= '0;
                end
            end else begin
                if (found) begin
                    r_ext_len <= r_ext_len + sba_pkg::LEN_W'(idx - r_lo);
                end else begin
                    r_ext_len <= r_ext_len
                               + sba_pkg::LEN_W'(7'(sba_pkg::WORD_W) - 7'(r_lo));
                    r_word    <= r_word + sba_pkg::WIDX_W'(1);
                    r_lo      <= '0;
                end
            end
        end
        if (i_cmd.emit) begin
            r_out.status        <= r_status;
            r_out.extent_start  <= r_ext_start;
            r_out.extent_length <= r_ext_len;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

### hdl/sector_bitmap_allocator.sv
// Channel    Dir  Handshake          Payload
// i_req      in   valid/ready        opcode, start_sector, range_length
// o_rsp      out  valid/ready        status, extent_start, extent_length
// i_cfg_*    in   write enable only  sectors_in_use (11 bits)
//
// Cycles: one request at a time. Mark range: 3 + 2 per 64-sector word touched; search:
//   3 + 2 per word visited + 1 where the free extent begins. Registered map reads set the pace.
// Reset: after i_rst_n the map is zeroed by a pass of ceil(MAX_SECTORS/64) cycles,
//   one word per cycle; i_req.ready stays low until it ends.
// Stalls: the response sits in an output register; the next request is taken
//   while it waits, but its own response holds until the register frees.
module sector_bitmap_allocator #(
    parameter int MAX_SECTORS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sba_pkg::CFG_W-1:0]  i_cfg_wdata,
    sba_req_if.sink                    i_req,
    sba_rsp_if.source                  o_rsp
);

    sba_pkg::t_cmd cmd;
    sba_pkg::t_sts sts;
    sba_pkg::t_req req;
    sba_pkg::t_rsp rsp;
    logic          rsp_valid;

    // pack request fields for the datapath
    assign req.opcode       = i_req.opcode;
    assign req.start_sector = i_req.start_sector;
    assign req.range_length = i_req.range_length;

    // sequencer: clear pass, request decode, map word walk
    sba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // map memory, range masks, free/used search, output register
    sba_dp #(
        .MAX_SECTORS(MAX_SECTORS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rsp_valid(rsp_valid),
        .i_rsp_ready(o_rsp.ready),
        .o_rsp      (rsp)
    );

    assign o_rsp.valid         = rsp_valid;
    assign o_rsp.status        = rsp.status;
    assign o_rsp.extent_start  = rsp.extent_start;
    assign o_rsp.extent_length = rsp.extent_length;

endmodule
